/* hw/rtl/interval_timer_counter0_core_macros.svh */
// Assertion macros shared by the interval timer counter 0 RTL.
`ifndef INTERVAL_TIMER_COUNTER0_CORE_MACROS_SVH
`define INTERVAL_TIMER_COUNTER0_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ITC0_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("itc0 check failed");
`define ITC0_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("itc0 check failed");
`else
`define ITC0_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define ITC0_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

/* hw/rtl/itc0_pkg.sv */
// Types and constants of the interval timer counter 0 block.
package itc0_pkg;

   typedef enum logic [1:0] {
      OP_CONTROL = 2'd0,
      OP_DATA_WR = 2'd1,
      OP_DATA_RD = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACC_LATCH   = 2'd0,
      ACC_LOW     = 2'd1,
      ACC_HIGH    = 2'd2,
      ACC_LOW_HIGH = 2'd3
   } access_type;

   localparam logic [2:0] MODE_INT_ON_TC  = 3'd0;
   localparam logic [2:0] MODE_SQUARE     = 3'd3;
   localparam logic [2:0] MODE_SQUARE_ALT = 3'd7;

   localparam logic [1:0] PORT_COUNTER0 = 2'd0;
   localparam logic [1:0] PORT_COUNTER1 = 2'd1;

   localparam logic [7:0] STUB_UNREAD = 8'hFF;
   localparam logic [7:0] STUB_READ   = 8'h00;
   localparam logic [15:0] COUNT_ALL_ONES = 16'hFFFF;

   typedef struct packed {
      op_type      operation;
      logic [1:0]  port_offset;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_output;
   } rsp_item_type;

endpackage

/* hw/rtl/itc0_if.sv */
// Valid/ready channel interfaces for bus items and their results.
interface itc0_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [1:0] port_offset;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output port_offset, output data_byte,
                   input ready);
   modport sink (input valid, input operation, input port_offset, input data_byte,
                 output ready);
endinterface

interface itc0_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       timer_output;

   modport source (output valid, output read_data, output timer_output, input ready);
   modport sink (input valid, input read_data, input timer_output, output ready);
endinterface

/* hw/rtl/itc0_counter.sv */
// Counter 0 state registers and the per-item update logic.
`include "interval_timer_counter0_core_macros.svh"

module itc0_counter
   import itc0_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [15:0] count_ff, count_in;
   logic [15:0] reload_ff, reload_in;
   logic [15:0] latch_ff, latch_in;
   access_type  access_ff, access_in;
   logic [2:0]  mode_ff, mode_in;
   logic        toggle_ff, toggle_in;
   logic        programmed_ff, programmed_in;
   logic        output_ff, output_in;
   logic        stub_seen_ff, stub_seen_in;

   logic [15:0] written_count;
   logic [15:0] dec_count;
   logic [15:0] square_count;
   logic [7:0]  rd_byte;

   always_comb begin
      case (access_ff)
         ACC_LOW:  written_count = {count_ff[15:8], item.data_byte};
         ACC_HIGH: written_count = {item.data_byte, count_ff[7:0]};
         ACC_LOW_HIGH: begin
            written_count = toggle_ff ? {item.data_byte, count_ff[7:0]}
                                      : {count_ff[15:8], item.data_byte};
         end
         default:  written_count = count_ff;
      endcase
   end

   assign dec_count    = count_ff - 16'd1;
   assign square_count = (dec_count == COUNT_ALL_ONES) ? (reload_ff - 16'd1) : dec_count;

   always_comb begin
      count_in      = count_ff;
      reload_in     = reload_ff;
      latch_in      = latch_ff;
      access_in     = access_ff;
      mode_in       = mode_ff;
      toggle_in     = toggle_ff;
      programmed_in = programmed_ff;
      output_in     = output_ff;
      stub_seen_in  = stub_seen_ff;
      rd_byte       = 8'd0;
      case (item.operation)
         OP_CONTROL: begin
            programmed_in = 1'b1;
            // Control words with the counter select bits set address other counters.
            if (item.data_byte[7:6] == 2'b00) begin
               if (access_type'(item.data_byte[5:4]) == ACC_LATCH) begin
                  latch_in  = count_ff;
                  access_in = ACC_LATCH;
               end else begin
                  access_in = access_type'(item.data_byte[5:4]);
                  mode_in   = item.data_byte[3:1];
               end
               toggle_in = 1'b0;
            end
         end
         OP_DATA_WR: begin
            if (item.port_offset == PORT_COUNTER0) begin
               count_in  = written_count;
               reload_in = written_count;
               toggle_in = ~toggle_ff;
            end
         end
         OP_DATA_RD: begin
            if (item.port_offset != PORT_COUNTER0) begin
               rd_byte = stub_seen_ff ? STUB_READ : STUB_UNREAD;
               if (item.port_offset == PORT_COUNTER1) begin
                  stub_seen_in = 1'b1;
               end
            end else begin
               case (access_ff)
                  ACC_LATCH: rd_byte = toggle_ff ? latch_ff[15:8] : latch_ff[7:0];
                  ACC_LOW:   rd_byte = count_ff[7:0];
                  ACC_HIGH:  rd_byte = count_ff[15:8];
                  default:   rd_byte = toggle_ff ? count_ff[15:8] : count_ff[7:0];
               endcase
               toggle_in = ~toggle_ff;
            end
         end
         OP_TICK: begin
            if (programmed_ff) begin
               if (mode_ff == MODE_INT_ON_TC) begin
                  count_in = dec_count;
                  if (dec_count == 16'd0) begin
                     output_in = 1'b1;
                  end
               end else if (mode_ff == MODE_SQUARE || mode_ff == MODE_SQUARE_ALT) begin
                  count_in  = square_count;
                  output_in = (square_count >= {1'b0, reload_ff[15:1]});
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign result.read_data    = rd_byte;
   assign result.timer_output = output_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= 16'd0;
         reload_ff     <= 16'd0;
         latch_ff      <= 16'd0;
         access_ff     <= ACC_LATCH;
         mode_ff       <= MODE_INT_ON_TC;
         toggle_ff     <= 1'b0;
         programmed_ff <= 1'b0;
         output_ff     <= 1'b0;
         stub_seen_ff  <= 1'b0;
      end else if (step) begin
         count_ff      <= count_in;
         reload_ff     <= reload_in;
         latch_ff      <= latch_in;
         access_ff     <= access_in;
         mode_ff       <= mode_in;
         toggle_ff     <= toggle_in;
         programmed_ff <= programmed_in;
         output_ff     <= output_in;
         stub_seen_ff  <= stub_seen_in;
      end
   end

   // The stub flag and the programmed flag are sticky once set.
   `ITC0_ASSERT_NEXT(a_stub_sticky, clock, reset, stub_seen_ff, stub_seen_ff)
   `ITC0_ASSERT_NEXT(a_prog_sticky, clock, reset, programmed_ff, programmed_ff)
   // Ticks are ignored until a control word arrives, so the output stays low.
   `ITC0_ASSERT_IMPLIES(a_idle_output, clock, reset, !programmed_ff, !output_ff)
   `ITC0_ASSERT_IMPLIES(a_read_only_data, clock, reset,
      step && (result.read_data != 8'd0), item.operation == OP_DATA_RD)

endmodule

/* hw/rtl/interval_timer_counter0_core.sv */
// Top level of the interval timer counter 0 block: input and result registers.
// Usage:
// The req channel carries one bus item per handshake: a control word write,
// a counter data write, a counter data read or a clock tick. The rsp channel
// returns exactly one item per request: the byte read (zero for anything but a
// data read) and the counter 0 output level after the item has been applied.
// An accepted item waits in the input register, where the counter state is
// updated and its result is captured in the result register, from which it
// is offered on the rsp channel. One item is taken per cycle while the
// receiver keeps up; the rate is set by the state update in itc0_counter.
// When the receiver stalls, the result register holds and the input register
// fills; req_chan.ready then drops until the result is taken.
// Synchronous reset returns the counter to zero, the mode to mode 0 with latch
// access, the output low and ticks ignored until the first control word;
// both registers are emptied.
`include "interval_timer_counter0_core_macros.svh"

module interval_timer_counter0_core
   import itc0_pkg::*;
(
   input logic         clock,
   input logic         reset,
   itc0_req_if.sink    req_chan,
   itc0_rsp_if.source  rsp_chan
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type step_result;
   logic         advance;
   logic         step;
   logic         req_take;

   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.operation   <= op_type'(req_chan.operation);
         in_item_ff.port_offset <= req_chan.port_offset;
         in_item_ff.data_byte   <= req_chan.data_byte;
      end
      if (step) begin
         rsp_item_ff <= step_result;
      end
   end

   itc0_counter u_counter (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (step_result)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_item_ff.read_data;
   assign rsp_chan.timer_output = rsp_item_ff.timer_output;

   `ITC0_ASSERT_NEXT(a_take_fills, clock, reset, req_take, in_valid_ff)
   `ITC0_ASSERT_NEXT(a_step_yields, clock, reset, step, rsp_valid_ff)
   `ITC0_ASSERT_NEXT(a_blocked_holds, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff))

endmodule
